// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== design/sabb_pkg.sv =====
// ----------------------------------------------------------------------------
// sabb_pkg
// Shared widths, defaults, state type and saturation helper for the split
// alignment breakpoint search.
// ----------------------------------------------------------------------------
`default_nettype none

package sabb_pkg;

   localparam int SCORE_W         = 16;
   localparam int SUM_W           = 18;
   localparam int PEN_W           = 7;
   localparam int LEN_W           = 10;
   localparam int DEF_MAX_LEN     = 1024;
   localparam int DEF_MAX_RESULTS = 64;

   localparam logic signed [PEN_W-1:0] PEN_RESET = -7'sd1;
   localparam logic signed [SUM_W-1:0] SUM_MAX   = 18'sh1FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN   = 18'sh20000;

   typedef enum logic [2:0] {
      S_LOAD,
      S_BEST,
      S_BEST_TAIL,
      S_COUNT,
      S_COUNT_TAIL,
      S_EMIT_RD,
      S_EMIT_EV,
      S_EMIT_OUT
   } state_type;

   // clamp a one-bit-wider sum back to the 18-bit signed range
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
      logic signed [SUM_W-1:0] r;
      if (x[SUM_W] != x[SUM_W-1]) begin
         r = x[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         r = x[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/sabb_ram.sv =====
// ----------------------------------------------------------------------------
// sabb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sabb_ram #(
   parameter int WIDTH = sabb_pkg::SUM_W,
   parameter int DEPTH = sabb_pkg::DEF_MAX_LEN
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/split_alignment_best_breakpoint.sv =====
// Load: one score beat per cycle, req_tready high while no read is being searched.
// On the beat marked last: a best pass over all n elements, a count pass, then an emit
// walk that reads, evaluates and outputs each element up to the final result, held by
// any rsp_tready stalls. All passes share one add/saturate/compare unit fed by the two
// score RAMs. Results leave through a one-deep output register.
// Reset (synchronous, active high) clears the sequencer and counters; RAMs are not cleared.
// ----------------------------------------------------------------------------
// split_alignment_best_breakpoint
// Stores paired prefix scores of a read, then walks them to find the best
// split point and streams every tied (first length, second length) pair, up to MAX_RESULTS.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module split_alignment_best_breakpoint #(
   parameter int MAX_LEN     = sabb_pkg::DEF_MAX_LEN,
   parameter int MAX_RESULTS = sabb_pkg::DEF_MAX_RESULTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // config: insert_penalty
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data,      // [6:0] insert_penalty
   // score beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,     // [15:0] first_score, [31:16] second_score
   input  wire logic        req_tlast,     // last
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,     // [9:0] first_length, [19:10] second_length,
                                           // [37:20] best_score, [39:38] zero
   output logic             rsp_tuser,     // overflow
   output logic             rsp_tlast      // last_result
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int RES_W = $clog2(MAX_RESULTS + 2);
   localparam int SW    = sabb_pkg::SUM_W;
   localparam int FW    = sabb_pkg::SCORE_W;
   localparam int PW    = sabb_pkg::PEN_W;
   localparam int LW    = sabb_pkg::LEN_W;
   localparam int RUN_W = SW + IDX_W + 1;   // {own flag, origin, running}

   // ---------------------------------------------------------------- registers
   sabb_pkg::state_type    state_ff, state_in;
   logic signed [PW-1:0]   pen_ff, pen_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   load_ovf_ff, load_ovf_in;
   logic signed [SW-1:0]   r_prev_ff, r_prev_in;
   logic [IDX_W-1:0]       org_prev_ff, org_prev_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       ev_idx_ff;
   logic                   rv_ff, rv_in;
   logic signed [SW-1:0]   best_ff, best_in;
   logic [RES_W-1:0]       res_cnt_ff, res_cnt_in;
   logic [RES_W-1:0]       emit_cnt_ff, emit_cnt_in;
   logic                   own_pend_ff, own_pend_in;
   logic                   org_pend_ff, org_pend_in;
   logic [IDX_W-1:0]       org_val_ff, org_val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]          out_len1_ff, out_len1_in;
   logic [LW-1:0]          out_len2_ff, out_len2_in;
   logic signed [SW-1:0]   out_best_ff, out_best_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic                   out_last_ff, out_last_in;

   // ---------------------------------------------------------------- datapath
   logic                   req_fire;
   logic signed [FW-1:0]   fs, ss;
   logic signed [SW-1:0]   fs_ext, ext, r_new;
   logic [IDX_W-1:0]       org_new, wr_idx;
   logic                   own_new, wr_en, ext_wins;
   logic [CNT_W-1:0]       last_idx, len2_full;
   logic [IDX_W-1:0]       sec_addr;
   logic                   at_end;
   logic [RUN_W-1:0]       run_wr, run_rd;
   logic [FW-1:0]          sec_rd;
   logic signed [SW-1:0]   rd_run;
   logic [IDX_W-1:0]       rd_org;
   logic                   rd_own;
   logic signed [SW-1:0]   split_sum;
   logic                   hit;
   logic [1:0]             inc;
   logic [RES_W:0]         res_sum;
   logic                   dropped;
   logic [RES_W-1:0]       kmax;
   logic                   out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == sabb_pkg::S_LOAD);
   assign req_fire   = req_tvalid && req_tready;

   assign fs     = req_tdata[FW-1:0];
   assign ss     = req_tdata[2*FW-1:FW];
   assign fs_ext = {{(SW-FW){fs[FW-1]}}, fs};
   assign ext    = sabb_pkg::sat_sum({r_prev_ff[SW-1], r_prev_ff}
                                     + {{(SW+1-PW){pen_ff[PW-1]}}, pen_ff});
   assign ext_wins = (ext >= fs_ext);
   assign wr_idx   = count_ff[IDX_W-1:0];

   always_comb begin
      if (count_ff == '0) begin
         r_new   = fs_ext;
         org_new = '0;
      end else if (ext_wins) begin
         r_new   = ext;
         org_new = org_prev_ff;
      end else begin
         r_new   = fs_ext;
         org_new = wr_idx;
      end
   end
   assign own_new = (r_new == fs_ext);
   assign wr_en   = req_fire && (count_ff < CNT_W'(MAX_LEN));
   assign run_wr  = {own_new, org_new, r_new};

   // walk addressing: running side at i, second side at n-1-i
   assign last_idx  = count_ff - CNT_W'(1);
   assign len2_full = last_idx - CNT_W'(i_ff);
   assign sec_addr  = len2_full[IDX_W-1:0];
   assign at_end    = (CNT_W'(i_ff) == last_idx);

   sabb_ram #(.WIDTH(RUN_W), .DEPTH(MAX_LEN)) u_run_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (run_wr),
      .rd_addr (i_ff),
      .rd_data (run_rd)
   );

   sabb_ram #(.WIDTH(FW), .DEPTH(MAX_LEN)) u_sec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (ss),
      .rd_addr (sec_addr),
      .rd_data (sec_rd)
   );

   assign rd_run = run_rd[SW-1:0];
   assign rd_org = run_rd[SW+IDX_W-1:SW];
   assign rd_own = run_rd[RUN_W-1];

   // shared add / saturate / compare unit
   assign split_sum = sabb_pkg::sat_sum({rd_run[SW-1], rd_run}
                                        + {{(SW+1-FW){sec_rd[FW-1]}}, sec_rd});
   assign hit = (split_sum == best_ff);
   assign inc = {1'b0, hit && rd_own} + {1'b0, hit && (rd_org != ev_idx_ff)};
   assign res_sum = {1'b0, res_cnt_ff} + (RES_W+1)'(inc);

   assign dropped  = (res_cnt_ff > RES_W'(MAX_RESULTS));
   assign kmax     = dropped ? RES_W'(MAX_RESULTS) : res_cnt_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      pen_in       = pen_ff;
      count_in     = count_ff;
      load_ovf_in  = load_ovf_ff;
      r_prev_in    = r_prev_ff;
      org_prev_in  = org_prev_ff;
      i_in         = i_ff;
      rv_in        = (state_ff == sabb_pkg::S_BEST) || (state_ff == sabb_pkg::S_COUNT);
      best_in      = best_ff;
      res_cnt_in   = res_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      own_pend_in  = own_pend_ff;
      org_pend_in  = org_pend_ff;
      org_val_in   = org_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_len1_in  = out_len1_ff;
      out_len2_in  = out_len2_ff;
      out_best_in  = out_best_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;

      if (csr_valid) begin
         pen_in = csr_data[PW-1:0];
      end

      // evaluation of read data issued in the previous cycle
      if (rv_ff && (state_ff == sabb_pkg::S_BEST || state_ff == sabb_pkg::S_BEST_TAIL)) begin
         if (split_sum > best_ff) begin
            best_in = split_sum;
         end
      end
      if (rv_ff && (state_ff == sabb_pkg::S_COUNT || state_ff == sabb_pkg::S_COUNT_TAIL)) begin
         if (res_sum > (RES_W+1)'(MAX_RESULTS + 1)) begin
            res_cnt_in = RES_W'(MAX_RESULTS + 1);
         end else begin
            res_cnt_in = res_sum[RES_W-1:0];
         end
      end

      unique case (state_ff)
         sabb_pkg::S_LOAD: begin
            if (req_fire) begin
               if (wr_en) begin
                  r_prev_in   = r_new;
                  org_prev_in = org_new;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  load_ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in   = sabb_pkg::S_BEST;
                  i_in       = '0;
                  best_in    = sabb_pkg::SUM_MIN;
                  res_cnt_in = '0;
               end
            end
         end
         sabb_pkg::S_BEST: begin
            if (at_end) begin
               i_in     = '0;
               state_in = sabb_pkg::S_BEST_TAIL;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         sabb_pkg::S_BEST_TAIL: begin
            state_in = sabb_pkg::S_COUNT;
         end
         sabb_pkg::S_COUNT: begin
            if (at_end) begin
               i_in     = '0;
               state_in = sabb_pkg::S_COUNT_TAIL;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         sabb_pkg::S_COUNT_TAIL: begin
            emit_cnt_in = '0;
            state_in    = sabb_pkg::S_EMIT_RD;
         end
         sabb_pkg::S_EMIT_RD: begin
            state_in = sabb_pkg::S_EMIT_EV;
         end
         sabb_pkg::S_EMIT_EV: begin
            own_pend_in = hit && rd_own;
            org_pend_in = hit && (rd_org != i_ff);
            org_val_in  = rd_org;
            state_in    = sabb_pkg::S_EMIT_OUT;
         end
         sabb_pkg::S_EMIT_OUT: begin
            if (own_pend_ff || org_pend_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  out_len1_in  = own_pend_ff ? LW'(i_ff) : LW'(org_val_ff);
                  out_len2_in  = LW'(len2_full);
                  out_best_in  = best_ff;
                  out_ovf_in   = load_ovf_ff || dropped;
                  out_last_in  = (emit_cnt_ff + RES_W'(1) == kmax);
                  emit_cnt_in  = emit_cnt_ff + RES_W'(1);
                  if (own_pend_ff) begin
                     own_pend_in = 1'b0;
                  end else begin
                     org_pend_in = 1'b0;
                  end
                  if (emit_cnt_ff + RES_W'(1) == kmax) begin
                     state_in    = sabb_pkg::S_LOAD;
                     count_in    = '0;
                     load_ovf_in = 1'b0;
                     best_in     = sabb_pkg::SUM_MIN;
                     own_pend_in = 1'b0;
                     org_pend_in = 1'b0;
                  end
               end
            end else if (at_end) begin
               // unreachable when the count pass is right; fall back to idle
               state_in    = sabb_pkg::S_LOAD;
               count_in    = '0;
               load_ovf_in = 1'b0;
               best_in     = sabb_pkg::SUM_MIN;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = sabb_pkg::S_EMIT_RD;
            end
         end
         default: begin
            state_in = sabb_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sabb_pkg::S_LOAD;
         pen_ff       <= sabb_pkg::PEN_RESET;
         count_ff     <= '0;
         load_ovf_ff  <= 1'b0;
         rv_ff        <= 1'b0;
         best_ff      <= sabb_pkg::SUM_MIN;
         res_cnt_ff   <= '0;
         emit_cnt_ff  <= '0;
         own_pend_ff  <= 1'b0;
         org_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_ff       <= pen_in;
         count_ff     <= count_in;
         load_ovf_ff  <= load_ovf_in;
         rv_ff        <= rv_in;
         best_ff      <= best_in;
         res_cnt_ff   <= res_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         own_pend_ff  <= own_pend_in;
         org_pend_ff  <= org_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_prev_ff   <= r_prev_in;
      org_prev_ff <= org_prev_in;
      i_ff        <= i_in;
      ev_idx_ff   <= i_ff;
      org_val_ff  <= org_val_in;
      out_len1_ff <= out_len1_in;
      out_len2_ff <= out_len2_in;
      out_best_ff <= out_best_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_best_ff, out_len2_ff, out_len1_ff};
   assign rsp_tuser  = out_ovf_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(MAX_LEN))
   `ASSERT_NEVER(a_emit_bound, clock, reset, emit_cnt_ff > RES_W'(MAX_RESULTS))
   `ASSERT_PROP(a_last_to_idle, clock, reset, (state_ff == sabb_pkg::S_EMIT_OUT && rsp_valid_in && !rsp_valid_ff && out_last_in) |=> (state_ff == sabb_pkg::S_LOAD))
   `ASSERT_PROP(a_best_frozen, clock, reset, (state_ff == sabb_pkg::S_EMIT_EV) |-> $stable(best_ff))
   `ASSERT_PROP(a_walk_nonempty, clock, reset, (state_ff == sabb_pkg::S_BEST) |-> (count_ff != '0))

endmodule

`default_nettype wire
